// ===== hw/rtl/tcd_pkg.sv =====
`timescale 1ns / 1ps

package tcd_pkg;

	localparam int CH_W       = 16;
	localparam int IDX_W      = 4;
	localparam int KIND_W     = 3;
	localparam int RKIND_W    = 3;
	localparam int TX_W       = 2;
	localparam int CNT_W      = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int BATCH_LIMIT = 32;
	localparam int BATCH_W    = $clog2(BATCH_LIMIT);

	typedef enum logic [KIND_W-1:0] {
		K_TRIG_WORD   = 3'd0,
		K_SLOT_REQ    = 3'd1,
		K_SIG_REQ     = 3'd2,
		K_LOCAL_TRIG  = 3'd3,
		K_TICK        = 3'd4,
		K_LOAD_SLOT   = 3'd5,
		K_LOAD_SIGNAL = 3'd6
	} kind_t;

	typedef enum logic [RKIND_W-1:0] {
		RK_ACTION    = 3'd0,
		RK_STATUS    = 3'd1,
		RK_SLOT_INFO = 3'd2,
		RK_SIG_INFO  = 3'd3,
		RK_TRIGGER   = 3'd4
	} rkind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOT_COUNT   = 1'd0,
		REG_SIGNAL_COUNT = 1'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		OP_MATCH_EMIT  = 3'd0,
		OP_MATCH_SET   = 3'd1,
		OP_SET_ALL     = 3'd2,
		OP_INFO_REPORT = 3'd3,
		OP_TRIG_SEND   = 3'd4
	} wave_op_t;

	typedef struct packed {
		logic             step;
		wave_op_t         op;
		logic [CH_W-1:0]  channel;
		logic [CNT_W-1:0] count;
		logic             allow;
		logic             load_en;
		logic             trig_en;
		logic [IDX_W-1:0] index;
		logic [CH_W-1:0]  load_data;
	} cell_ctrl_t;

	typedef struct packed {
		logic             emit;
		logic             hit;
		logic             tail;
		logic [CH_W-1:0]  channel;
		logic [IDX_W-1:0] index;
	} chain_stat_t;

endpackage

// ===== hw/rtl/tcd_cell.sv =====
`timescale 1ns / 1ps

module tcd_cell import tcd_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cell_ctrl_t      ctrl,
	input  logic            tok_in,
	input  logic            done_in,
	output logic            tok_out,
	output logic            done_out,
	output logic            emit,
	output logic            hit,
	output logic [CH_W-1:0] chan
);

	logic            tok_q;
	logic            done_q;
	logic            info_q;
	logic            trig_q;
	logic [CH_W-1:0] chan_q;

	logic in_use;
	logic sel;
	logic active;
	logic match;
	logic stop;
	logic set_info;
	logic clr_info;
	logic clr_trig;

	assign in_use = CNT_W'(IDX) < ctrl.count;
	assign sel    = CNT_W'(IDX) == {1'b0, ctrl.index};
	assign active = ctrl.step && tok_q && !done_q && in_use;
	assign match  = chan_q == ctrl.channel;

	always_comb begin
		emit     = 1'b0;
		hit      = 1'b0;
		stop     = 1'b0;
		set_info = 1'b0;
		clr_info = 1'b0;
		clr_trig = 1'b0;
		case (ctrl.op)
			OP_MATCH_EMIT: begin
				hit  = active && match;
				emit = hit;
				stop = hit;
			end
			OP_MATCH_SET: begin
				hit      = active && match;
				set_info = hit;
				stop     = hit;
			end
			OP_SET_ALL: begin
				set_info = active;
			end
			OP_INFO_REPORT: begin
				stop     = active && info_q;
				emit     = stop && ctrl.allow;
				clr_info = emit;
			end
			OP_TRIG_SEND: begin
				emit     = active && trig_q && ctrl.allow;
				clr_trig = emit;
				stop     = active && trig_q && !ctrl.allow;
			end
			default: begin
			end
		endcase
	end

	assign tok_out  = tok_q;
	assign done_out = done_q || stop;
	assign chan     = chan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= 1'b0;
			done_q <= 1'b0;
			info_q <= 1'b0;
			trig_q <= 1'b0;
		end else begin
			if (ctrl.step) begin
				tok_q  <= tok_in;
				done_q <= done_in;
			end
			if (set_info) begin
				info_q <= 1'b1;
			end else if (clr_info) begin
				info_q <= 1'b0;
			end
			if (ctrl.trig_en && sel && in_use) begin
				trig_q <= 1'b1;
			end else if (clr_trig) begin
				trig_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_en && sel) begin
			chan_q <= ctrl.load_data;
		end
	end

endmodule

// ===== hw/rtl/tcd_chain.sv =====
`timescale 1ns / 1ps

module tcd_chain import tcd_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cell_ctrl_t  ctrl,
	input  logic        launch,
	output chain_stat_t stat
);

	logic                tok_link  [ENTRIES+1];
	logic                done_link [ENTRIES+1];
	logic                emit_v    [ENTRIES];
	logic                hit_v     [ENTRIES];
	logic [CH_W-1:0]     chan_v    [ENTRIES];

	assign tok_link[0]  = launch;
	assign done_link[0] = 1'b0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		tcd_cell #(.IDX(g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.tok_in   (tok_link[g]),
			.done_in  (done_link[g]),
			.tok_out  (tok_link[g+1]),
			.done_out (done_link[g+1]),
			.emit     (emit_v[g]),
			.hit      (hit_v[g]),
			.chan     (chan_v[g])
		);
	end

	always_comb begin
		stat      = '0;
		stat.tail = tok_link[ENTRIES];
		for (int j = 0; j < ENTRIES; j++) begin
			stat.hit = stat.hit | hit_v[j];
			if (emit_v[j]) begin
				stat.emit    = 1'b1;
				stat.channel = stat.channel | chan_v[j];
				stat.index   = stat.index | IDX_W'(j);
			end
		end
	end

endmodule

// ===== hw/rtl/trigger_channel_dispatcher_core.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// in        input      in_valid / in_ready     kind channel index last_in request_all tx_free
// out       output     out_valid / out_ready   result_kind channel_out index_out found last_out
// cfg       input      cfg_we                  cfg_index cfg_data
//
// loads and local triggers are written on acceptance; a trigger word or info request
// walks the slot or signal row of cells one cell a cycle while the output is not stalled
// a service tick walks the slot row, then the signal row twice
// reset clears all pending flags, the match flag and both counts; tables hold junk
// a full output register holds every row in place until the result is taken

module trigger_channel_dispatcher_core import tcd_pkg::*; #(
	parameter int SLOT_ENTRIES   = 16,
	parameter int SIGNAL_ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [KIND_W-1:0]    kind,
	input  logic [CH_W-1:0]      channel,
	input  logic [IDX_W-1:0]     index,
	input  logic                 last_in,
	input  logic                 request_all,
	input  logic [TX_W-1:0]      tx_free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [RKIND_W-1:0]   result_kind,
	output logic [CH_W-1:0]      channel_out,
	output logic [IDX_W-1:0]     index_out,
	output logic                 found,
	output logic                 last_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SLOT  = 6'b000010,
		S_SIG   = 6'b000100,
		S_TRIG  = 6'b001000,
		S_FIN   = 6'b010000,
		S_FLUSH = 6'b100000
	} state_t;

	state_t               state_q;
	logic                 launch_q;
	kind_t                kind_q;
	logic [CH_W-1:0]      ch_q;
	logic                 last_q;
	logic                 all_q;
	logic [TX_W-1:0]      tx_q;
	logic [BATCH_W-1:0]   batch_q;
	logic                 acc_q;
	logic                 wave_hit_q;
	logic [CNT_W-1:0]     slot_count_q;
	logic [CNT_W-1:0]     signal_count_q;

	logic                 hold_valid_q;
	rkind_t               hold_kind_q;
	logic [CH_W-1:0]      hold_ch_q;
	logic [IDX_W-1:0]     hold_idx_q;
	logic                 hold_found_q;

	logic                 out_valid_q;
	rkind_t               out_kind_q;
	logic [CH_W-1:0]      out_ch_q;
	logic [IDX_W-1:0]     out_idx_q;
	logic                 out_found_q;
	logic                 out_last_q;

	logic                 adv;
	logic                 accept;
	kind_t                kind_in;
	cell_ctrl_t           slot_ctrl;
	cell_ctrl_t           sig_ctrl;
	chain_stat_t          slot_stat;
	chain_stat_t          sig_stat;
	chain_stat_t          cur_stat;
	logic                 wave_end;
	state_t               wave_next;

	logic                 e_valid;
	logic                 e_fire;
	rkind_t               e_kind;
	logic [CH_W-1:0]      e_ch;
	logic [IDX_W-1:0]     e_idx;
	logic                 e_found;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;
	assign kind_in  = kind_t'(kind);

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q   <= '0;
			signal_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SLOT_COUNT:   slot_count_q   <= cfg_data;
				REG_SIGNAL_COUNT: signal_count_q <= cfg_data;
			endcase
		end
	end

	// row control
	always_comb begin
		slot_ctrl           = '0;
		slot_ctrl.step      = adv && (state_q == S_SLOT);
		slot_ctrl.channel   = ch_q;
		slot_ctrl.count     = slot_count_q;
		slot_ctrl.allow     = tx_q != '0;
		slot_ctrl.load_en   = accept && (kind_in == K_LOAD_SLOT);
		slot_ctrl.index     = index;
		slot_ctrl.load_data = channel;
		case (kind_q)
			K_SLOT_REQ: slot_ctrl.op = all_q ? OP_SET_ALL : OP_MATCH_SET;
			K_TICK:     slot_ctrl.op = OP_INFO_REPORT;
			default:    slot_ctrl.op = OP_MATCH_EMIT;
		endcase

		sig_ctrl           = '0;
		sig_ctrl.step      = adv && ((state_q == S_SIG) || (state_q == S_TRIG));
		sig_ctrl.channel   = ch_q;
		sig_ctrl.count     = signal_count_q;
		sig_ctrl.allow     = (state_q == S_TRIG) ? ((batch_q != '0) || (tx_q != '0))
		                                         : (tx_q != '0);
		sig_ctrl.load_en   = accept && (kind_in == K_LOAD_SIGNAL);
		sig_ctrl.trig_en   = accept && (kind_in == K_LOCAL_TRIG);
		sig_ctrl.index     = index;
		sig_ctrl.load_data = channel;
		if (state_q == S_TRIG) begin
			sig_ctrl.op = OP_TRIG_SEND;
		end else if (kind_q == K_SIG_REQ) begin
			sig_ctrl.op = all_q ? OP_SET_ALL : OP_MATCH_SET;
		end else begin
			sig_ctrl.op = OP_INFO_REPORT;
		end
	end

	tcd_chain #(.ENTRIES(SLOT_ENTRIES)) u_slot_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (slot_ctrl),
		.launch (launch_q),
		.stat   (slot_stat)
	);

	tcd_chain #(.ENTRIES(SIGNAL_ENTRIES)) u_sig_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (sig_ctrl),
		.launch (launch_q),
		.stat   (sig_stat)
	);

	assign cur_stat = (state_q == S_SLOT) ? slot_stat : sig_stat;
	assign wave_end = adv && cur_stat.tail;

	always_comb begin
		case (state_q)
			S_SLOT:  wave_next = (kind_q == K_TICK) ? S_SIG : S_FIN;
			S_SIG:   wave_next = (kind_q == K_TICK) ? S_TRIG : S_FIN;
			default: wave_next = S_FLUSH;
		endcase
	end

	// result produced this cycle
	always_comb begin
		e_valid = 1'b0;
		e_kind  = RK_ACTION;
		e_ch    = cur_stat.channel;
		e_idx   = cur_stat.index;
		e_found = 1'b0;
		case (state_q)
			S_SLOT: begin
				e_valid = slot_stat.emit;
				e_kind  = (kind_q == K_TRIG_WORD) ? RK_ACTION : RK_SLOT_INFO;
			end
			S_SIG: begin
				e_valid = sig_stat.emit;
				e_kind  = RK_SIG_INFO;
			end
			S_TRIG: begin
				e_valid = sig_stat.emit;
				e_kind  = RK_TRIGGER;
			end
			S_FIN: begin
				e_valid = all_q || last_q;
				e_kind  = RK_STATUS;
				e_ch    = '0;
				e_idx   = '0;
				e_found = all_q || acc_q || wave_hit_q;
			end
			default: begin
			end
		endcase
	end

	assign e_fire = e_valid && adv;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			launch_q   <= 1'b0;
			kind_q     <= K_TRIG_WORD;
			ch_q       <= '0;
			last_q     <= 1'b0;
			all_q      <= 1'b0;
			tx_q       <= '0;
			batch_q    <= '0;
			acc_q      <= 1'b0;
			wave_hit_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q     <= kind_in;
						ch_q       <= channel;
						last_q     <= last_in;
						all_q      <= request_all &&
						              ((kind_in == K_SLOT_REQ) || (kind_in == K_SIG_REQ));
						tx_q       <= tx_free;
						batch_q    <= '0;
						wave_hit_q <= 1'b0;
						unique case (kind_in)
							K_TRIG_WORD, K_SLOT_REQ, K_TICK: begin
								state_q  <= S_SLOT;
								launch_q <= 1'b1;
							end
							K_SIG_REQ: begin
								state_q  <= S_SIG;
								launch_q <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				S_SLOT, S_SIG, S_TRIG: begin
					if (adv) begin
						if (cur_stat.hit) begin
							wave_hit_q <= 1'b1;
						end
						if (cur_stat.emit && (kind_q == K_TICK)) begin
							if (state_q == S_TRIG) begin
								if (batch_q == '0) begin
									tx_q <= tx_q - TX_W'(1);
								end
								if (batch_q == BATCH_W'(BATCH_LIMIT - 1)) begin
									batch_q <= '0;
								end else begin
									batch_q <= batch_q + BATCH_W'(1);
								end
							end else begin
								tx_q <= tx_q - TX_W'(1);
							end
						end
						if (wave_end) begin
							state_q  <= wave_next;
							launch_q <= (wave_next == S_SIG) || (wave_next == S_TRIG);
						end else begin
							launch_q <= 1'b0;
						end
					end
				end
				S_FIN: begin
					if (adv) begin
						if (all_q || last_q) begin
							acc_q <= 1'b0;
						end else if (wave_hit_q) begin
							acc_q <= 1'b1;
						end
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (adv) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// one result is held back until it is known whether it is the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (adv) begin
			out_valid_q <= hold_valid_q && (e_fire || (state_q == S_FLUSH));
			if (e_fire) begin
				hold_valid_q <= 1'b1;
			end else if (state_q == S_FLUSH) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && hold_valid_q && (e_fire || (state_q == S_FLUSH))) begin
			out_kind_q  <= hold_kind_q;
			out_ch_q    <= hold_ch_q;
			out_idx_q   <= hold_idx_q;
			out_found_q <= hold_found_q;
			out_last_q  <= state_q == S_FLUSH;
		end
		if (e_fire) begin
			hold_kind_q  <= e_kind;
			hold_ch_q    <= e_ch;
			hold_idx_q   <= e_idx;
			hold_found_q <= e_found;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign channel_out = out_ch_q;
	assign index_out   = out_idx_q;
	assign found       = out_found_q;
	assign last_out    = out_last_q;

	a_idle_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !hold_valid_q)
		else $error("held result left over at idle");

	a_batch_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TRIG) && sig_stat.emit && (tx_q == '0) |-> (batch_q != '0))
		else $error("trigger sent without a transmit slot");

	a_single_cycle_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ((kind == K_LOAD_SLOT) || (kind == K_LOAD_SIGNAL) ||
		(kind == K_LOCAL_TRIG)) |=> in_ready)
		else $error("table write did not return to idle");

endmodule
